@@ design/bearing_and_distance_unit_assert.svh @@
// assertion macros for the bearing and distance unit
`ifndef BEARING_AND_DISTANCE_UNIT_ASSERT_SVH
`define BEARING_AND_DISTANCE_UNIT_ASSERT_SVH
`ifndef SYNTH
// clocked check, quiet while reset is high
`define BDU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also runs through reset
`define BDU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDU_ASSERT(label, clk, rst, prop, msg)
`define BDU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ design/brgdist_pkg.sv @@
// shared widths, constants and types of the bearing and distance unit
package brgdist_pkg;

   // port field widths
   localparam int IN_W   = 32;
   localparam int BRG_W  = 16;
   localparam int DIST_W = 33;

   // working widths
   localparam int DIFF_W     = 33;
   localparam int MAG_W      = 32;
   localparam int GUARD_BITS = 16;
   localparam int CORDIC_W   = 51;
   localparam int ZW         = 32;
   localparam int ANG_FRAC   = 24;
   localparam int ANG_W      = 33;
   localparam int PROD_W     = 40;
   localparam int SCALE_W    = 7;
   localparam int SQ_W       = 64;
   localparam int SUM_W      = 65;
   localparam int ROOT_W     = 34;
   localparam int REM_W      = 69;

   // stage counts
   localparam int TABLE_LEN   = 32;
   localparam int ROOT_STEPS  = 34;
   localparam int DIST_STAGES = ROOT_STEPS + 3;
   localparam int BRG_TAIL    = 4;
   localparam int FRONT_STAGES = 2;

   // angle constants, degrees scaled by 2^24
   localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90) << ANG_FRAC;
   localparam logic [ANG_W-1:0] ANG_180 = ANG_W'(180) << ANG_FRAC;
   localparam logic [ANG_W-1:0] ANG_270 = ANG_W'(270) << ANG_FRAC;
   localparam logic [ANG_W-1:0] ANG_360 = ANG_W'(360) << ANG_FRAC;

   // bearing output scale and wrap point
   localparam logic [SCALE_W-1:0] BRG_SCALE = SCALE_W'(100);
   localparam logic [BRG_W-1:0]   BRG_WRAP  = BRG_W'(36000);

   // atan(2^-i) in degrees scaled by 2^24, rounded to nearest
   localparam logic [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
      754974720, 445687602, 235489088, 119537938,
      60000934, 30029717, 15018523, 7509719,
      3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335,
      14668, 7334, 3667, 1833,
      917, 458, 229, 115,
      57, 29, 14, 7,
      4, 2, 1, 0
   };

   // direction of the destination as seen from the reference point
   typedef enum logic [3:0] {
      DIR_NONE,
      DIR_NORTH,
      DIR_EAST,
      DIR_SOUTH,
      DIR_WEST,
      DIR_NE,
      DIR_SE,
      DIR_SW,
      DIR_NW
   } dir_type;

   // one rotation stage of the vectoring pipeline
   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [ZW-1:0]       z;
      dir_type                    dir;
   } rot_type;

endpackage

@@ design/brgdist_if.sv @@
// request and response channel interfaces of the bearing and distance unit
interface brgdist_req_if;
   import brgdist_pkg::*;

   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] ref_x;
   logic signed [IN_W-1:0] ref_y;
   logic signed [IN_W-1:0] dest_x;
   logic signed [IN_W-1:0] dest_y;

   modport source (output valid, ref_x, ref_y, dest_x, dest_y, input ready);
   modport sink (input valid, ref_x, ref_y, dest_x, dest_y, output ready);
endinterface

interface brgdist_rsp_if;
   import brgdist_pkg::*;

   logic              valid;
   logic              ready;
   logic [BRG_W-1:0]  bearing;
   logic [DIST_W-1:0] distance;

   modport source (output valid, bearing, distance, input ready);
   modport sink (input valid, bearing, distance, output ready);
endinterface

@@ design/bearing_and_distance_unit.sv @@
// Bearing and distance unit: takes a reference and a destination point (signed metres with
// 8 fraction bits) and returns the compass bearing in hundredths of a degree and the rounded
// Euclidean distance. It accepts one point pair every clock cycle while the output is not
// stalled. The pipeline depth is set by the distance path: two front
// stages (differences, magnitudes), a 32x32 squaring stage, a sum stage, one stage per root
// bit of the 34-bit square root and a rounding stage. The bearing runs in parallel through
// CORDIC_STAGES vectoring stages (at most 32), clamp, quadrant fold, scale and rounding
// stages, then a short delay line that lines it up with the distance. All stages advance
// together; when a result waits at the output register and the sink holds ready low, the
// whole pipeline holds and no new pair is taken.
`include "bearing_and_distance_unit_assert.svh"

module bearing_and_distance_unit #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic          clock,
   input  logic          reset,
   brgdist_req_if.sink   req_chan,
   brgdist_rsp_if.source rsp_chan
);
   import brgdist_pkg::*;

   localparam int ROT_STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int BRG_PAD    = DIST_STAGES - BRG_TAIL - ROT_STAGES;
   localparam int PIPE_DEPTH = FRONT_STAGES + DIST_STAGES;

   // pipeline control
   logic                  pipe_en;
   logic                  take_req;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;

   assign pipe_en           = ~vld_ff[PIPE_DEPTH-1] | rsp_chan.ready;
   assign req_chan.ready    = pipe_en & ~reset;
   assign take_req          = req_chan.valid & req_chan.ready;
   assign vld_in            = {vld_ff[PIPE_DEPTH-2:0], take_req};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   // stage a: coordinate differences
   logic [DIFF_W-1:0] dx_ff, dy_ff, dx_in, dy_in;

   assign dx_in = {req_chan.dest_x[IN_W-1], req_chan.dest_x}
                - {req_chan.ref_x[IN_W-1], req_chan.ref_x};
   assign dy_in = {req_chan.dest_y[IN_W-1], req_chan.dest_y}
                - {req_chan.ref_y[IN_W-1], req_chan.ref_y};

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // stage b: magnitudes and direction class
   logic [MAG_W-1:0]  ax_ff, ay_ff, ax_in, ay_in;
   logic [DIFF_W-1:0] dx_neg, dy_neg;
   dir_type           dir_ff, dir_in;
   logic              dx_zero, dy_zero;

   assign dx_neg  = ~dx_ff + DIFF_W'(1);
   assign dy_neg  = ~dy_ff + DIFF_W'(1);
   assign ax_in   = dx_ff[DIFF_W-1] ? dx_neg[MAG_W-1:0] : dx_ff[MAG_W-1:0];
   assign ay_in   = dy_ff[DIFF_W-1] ? dy_neg[MAG_W-1:0] : dy_ff[MAG_W-1:0];
   assign dx_zero = (dx_ff == '0);
   assign dy_zero = (dy_ff == '0);

   always_comb begin
      if (dx_zero && dy_zero) begin
         dir_in = DIR_NONE;
      end else if (dy_zero) begin
         dir_in = dx_ff[DIFF_W-1] ? DIR_WEST : DIR_EAST;
      end else if (dx_zero) begin
         dir_in = dy_ff[DIFF_W-1] ? DIR_SOUTH : DIR_NORTH;
      end else if (!dy_ff[DIFF_W-1]) begin
         dir_in = dx_ff[DIFF_W-1] ? DIR_NW : DIR_NE;
      end else begin
         dir_in = dx_ff[DIFF_W-1] ? DIR_SW : DIR_SE;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         dir_ff <= dir_in;
      end
   end

   // distance: squares
   logic [SQ_W-1:0] sqx_ff, sqy_ff, sqx_in, sqy_in;

   assign sqx_in = SQ_W'(ax_ff) * SQ_W'(ax_ff);
   assign sqy_in = SQ_W'(ay_ff) * SQ_W'(ay_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
      end
   end

   // distance: sum of squares
   logic [SUM_W-1:0] sum_ff, sum_in;

   assign sum_in = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sum_ff <= sum_in;
      end
   end

   // distance: one root bit per stage, most significant first
   logic [ROOT_W-1:0] root_ff [ROOT_STEPS];
   logic [REM_W-1:0]  rem_ff  [ROOT_STEPS];

   for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
      localparam int BIT = ROOT_STEPS - 1 - j;

      logic [ROOT_W-1:0] root_prev, root_in;
      logic [REM_W-1:0]  rem_prev, rem_in, trial, diff;
      logic              borrow;

      if (j == 0) begin : g_first
         assign root_prev = '0;
         assign rem_prev  = REM_W'(sum_ff);
      end else begin : g_next
         assign root_prev = root_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
      end

      // (r + 2^b)^2 - r^2, with r holding only bits above b
      assign trial            = (REM_W'(root_prev) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));
      assign {borrow, diff}   = {1'b0, rem_prev} - {1'b0, trial};
      assign root_in          = borrow ? root_prev : (root_prev | (ROOT_W'(1) << BIT));
      assign rem_in           = borrow ? rem_prev : diff;

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            root_ff[j] <= root_in;
            rem_ff[j]  <= rem_in;
         end
      end
   end

   // distance: round to nearest, output register
   logic [DIST_W-1:0] dist_ff, dist_in;

   assign dist_in = (rem_ff[ROOT_STEPS-1] > REM_W'(root_ff[ROOT_STEPS-1]))
                  ? DIST_W'(root_ff[ROOT_STEPS-1] + ROOT_W'(1))
                  : DIST_W'(root_ff[ROOT_STEPS-1]);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dist_ff <= dist_in;
      end
   end

   // bearing: vectoring stages, angle measured from the north axis
   rot_type rot_ff [ROT_STAGES];

   for (genvar k = 0; k < ROT_STAGES; k++) begin : g_rot
      rot_type                    rot_prev, rot_in;
      logic signed [CORDIC_W-1:0] x_prev, y_prev, xs, ys;
      logic signed [ZW-1:0]       z_prev;

      if (k == 0) begin : g_first
         assign rot_prev.x   = signed'({{(CORDIC_W - MAG_W - GUARD_BITS){1'b0}}, ay_ff,
                                        {GUARD_BITS{1'b0}}});
         assign rot_prev.y   = signed'({{(CORDIC_W - MAG_W - GUARD_BITS){1'b0}}, ax_ff,
                                        {GUARD_BITS{1'b0}}});
         assign rot_prev.z   = '0;
         assign rot_prev.dir = dir_ff;
      end else begin : g_next
         assign rot_prev = rot_ff[k-1];
      end

      assign x_prev = rot_prev.x;
      assign y_prev = rot_prev.y;
      assign z_prev = rot_prev.z;
      assign xs     = x_prev >>> k;
      assign ys     = y_prev >>> k;

      // rotate toward the x axis
      always_comb begin
         rot_in.dir = rot_prev.dir;
         if (!y_prev[CORDIC_W-1]) begin
            rot_in.x = x_prev + ys;
            rot_in.y = y_prev - xs;
            rot_in.z = z_prev + signed'(ATAN_TABLE[k]);
         end else begin
            rot_in.x = x_prev - ys;
            rot_in.y = y_prev + xs;
            rot_in.z = z_prev - signed'(ATAN_TABLE[k]);
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            rot_ff[k] <= rot_in;
         end
      end
   end

   // bearing: clamp the first-quadrant angle to 0..90 degrees
   logic [ANG_W-1:0]     quad_ff, quad_in;
   dir_type              qdir_ff;
   logic signed [ZW-1:0] z_last;

   assign z_last = rot_ff[ROT_STAGES-1].z;

   always_comb begin
      if (z_last[ZW-1]) begin
         quad_in = '0;
      end else if ($unsigned(z_last) > ZW'(ANG_90)) begin
         quad_in = ANG_90;
      end else begin
         quad_in = ANG_W'($unsigned(z_last));
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         quad_ff <= quad_in;
         qdir_ff <= rot_ff[ROT_STAGES-1].dir;
      end
   end

   // bearing: fold into the full circle
   logic [ANG_W-1:0] ang_ff, ang_in;

   always_comb begin
      case (qdir_ff)
         DIR_NONE:  ang_in = '0;
         DIR_NORTH: ang_in = '0;
         DIR_EAST:  ang_in = ANG_90;
         DIR_SOUTH: ang_in = ANG_180;
         DIR_WEST:  ang_in = ANG_270;
         DIR_NE:    ang_in = quad_ff;
         DIR_SE:    ang_in = ANG_180 - quad_ff;
         DIR_SW:    ang_in = ANG_180 + quad_ff;
         DIR_NW:    ang_in = ANG_360 - quad_ff;
         default:   ang_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ang_ff <= ang_in;
      end
   end

   // bearing: scale to hundredths of a degree
   logic [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = PROD_W'(ang_ff) * PROD_W'(BRG_SCALE);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         prod_ff <= prod_in;
      end
   end

   // bearing: round half up, wrap a full circle to zero, then align with distance
   logic [PROD_W-1:0] prod_rnd;
   logic [BRG_W-1:0]  brg_raw, brg_in;
   logic [BRG_W-1:0]  brg_ff [BRG_PAD+1];

   assign prod_rnd = prod_ff + (PROD_W'(1) << (ANG_FRAC - 1));
   assign brg_raw  = prod_rnd[ANG_FRAC +: BRG_W];
   assign brg_in   = (brg_raw >= BRG_WRAP) ? (brg_raw - BRG_WRAP) : brg_raw;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         brg_ff[0] <= brg_in;
      end
   end

   for (genvar p = 1; p <= BRG_PAD; p++) begin : g_brg_dly
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            brg_ff[p] <= brg_ff[p-1];
         end
      end
   end

   // response channel
   assign rsp_chan.valid    = vld_ff[PIPE_DEPTH-1];
   assign rsp_chan.bearing  = brg_ff[BRG_PAD];
   assign rsp_chan.distance = dist_ff;

   // checks
   `BDU_ASSERT(a_accept_enters, clock, reset, take_req |=> vld_ff[0], "accepted transfer did not enter the first stage")
   `BDU_ASSERT(a_stall_holds, clock, reset, !pipe_en |=> $stable(vld_ff), "valid bits moved during a stall")
   `BDU_ASSERT(a_empty_ready, clock, reset, !rsp_chan.valid |-> req_chan.ready, "request blocked with empty output register")
   `BDU_ASSERT(a_bearing_range, clock, reset, rsp_chan.valid |-> (rsp_chan.bearing < BRG_WRAP), "bearing beyond full circle")
   `BDU_ASSERT(a_zero_distance, clock, reset, rsp_chan.valid && (rsp_chan.distance == '0) |-> (rsp_chan.bearing == '0), "coincident points gave nonzero bearing")

endmodule

@@ tb/testbench.sv @@
// testbench for the bearing and distance unit: directed point pairs, then random pairs checked
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import brgdist_pkg::*;

   localparam int     STAGES       = 24;
   localparam int     RANDOM_ITEMS = 500;
   localparam int     IDLE_LIMIT   = 2000;
   localparam int     TAIL_CYCLES  = 60;
   localparam int     BRG_TOL      = 2;
   localparam longint DIST_TOL     = 2;
   localparam longint ONE_DEG      = 64'sd1 <<< 24;

   localparam logic signed [IN_W-1:0] PMIN = 32'sh8000_0000;
   localparam logic signed [IN_W-1:0] PMAX = 32'sh7fff_ffff;
   localparam logic [DIST_W-1:0]      SPAN = 33'h0_ffff_ffff;

   // atan(2^-i) in degrees scaled by 2^24
   localparam longint ARC_STEPS [32] = '{
      754974720, 445687602, 235489088, 119537938,
      60000934, 30029717, 15018523, 7509719,
      3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335,
      14668, 7334, 3667, 1833,
      917, 458, 229, 115,
      57, 29, 14, 7,
      4, 2, 1, 0
   };

   // bearing and distance, and whether they were typed in by hand
   typedef struct {
      bit                known;
      logic [BRG_W-1:0]  bearing;
      logic [DIST_W-1:0] distance;
   } fix_type;

   // one directed point pair
   typedef struct packed {
      logic signed [IN_W-1:0] ref_x;
      logic signed [IN_W-1:0] ref_y;
      logic signed [IN_W-1:0] dest_x;
      logic signed [IN_W-1:0] dest_y;
      bit                     known;
      logic [BRG_W-1:0]       bearing;
      logic [DIST_W-1:0]      distance;
   } point_case;

   // directed pairs: coincident points, the four axes, extremes, quadrants, wrap
   localparam point_case DIRECTED_CASES [23] = '{
      '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 16'd0, 33'd0},
      '{PMAX, PMAX, PMAX, PMAX, 1'b1, 16'd0, 33'd0},
      '{PMIN, PMIN, PMIN, PMIN, 1'b1, 16'd0, 33'd0},
      '{-32'sd5, 32'sd7, -32'sd5, 32'sd7, 1'b1, 16'd0, 33'd0},
      '{32'sd0, 32'sd0, 32'sd0, 32'sd256, 1'b1, 16'd0, 33'd256},
      '{32'sd0, 32'sd0, 32'sd256, 32'sd0, 1'b1, 16'd9000, 33'd256},
      '{32'sd0, 32'sd0, 32'sd0, -32'sd256, 1'b1, 16'd18000, 33'd256},
      '{32'sd0, 32'sd0, -32'sd256, 32'sd0, 1'b1, 16'd27000, 33'd256},
      '{32'sd0, 32'sd0, -32'sd1, 32'sd0, 1'b1, 16'd27000, 33'd1},
      '{PMIN, 32'sd0, PMAX, 32'sd0, 1'b1, 16'd9000, SPAN},
      '{PMAX, 32'sd0, PMIN, 32'sd0, 1'b1, 16'd27000, SPAN},
      '{32'sd0, PMIN, 32'sd0, PMAX, 1'b1, 16'd0, SPAN},
      '{32'sd0, PMAX, 32'sd0, PMIN, 1'b1, 16'd18000, SPAN},
      '{32'sd0, 32'sd0, 32'sd1, 32'sd1, 1'b0, 16'd0, 33'd0},
      '{32'sd0, 32'sd0, 32'sd1, -32'sd1, 1'b0, 16'd0, 33'd0},
      '{32'sd0, 32'sd0, -32'sd1, -32'sd1, 1'b0, 16'd0, 33'd0},
      '{32'sd0, 32'sd0, -32'sd1, 32'sd1, 1'b0, 16'd0, 33'd0},
      '{PMIN, PMIN, PMAX, PMAX, 1'b0, 16'd0, 33'd0},
      '{PMAX, PMAX, PMIN, PMIN, 1'b0, 16'd0, 33'd0},
      '{PMIN, PMAX, PMAX, PMIN, 1'b0, 16'd0, 33'd0},
      '{32'sd0, 32'sd0, -32'sd1, PMAX, 1'b0, 16'd0, 33'd0},
      '{32'sd0, 32'sd0, 32'sd1, PMIN, 1'b0, 16'd0, 33'd0},
      '{32'sd0, 32'sd0, PMAX, 32'sd1, 1'b0, 16'd0, 33'd0}
   };

   logic clock = 1'b0;
   logic reset;
   bit   steady;
   int   fails = 0;
   int   idle_cycles = 0;
   int   hold = 0;

   fix_type hand_answers [$];
   fix_type due_results [$];

   brgdist_req_if req_bus ();
   brgdist_rsp_if rsp_bus ();

   bearing_and_distance_unit #(.CORDIC_STAGES(STAGES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #4 clock = ~clock;

   // first-quadrant angle of (run, rise) in degrees scaled by 2^24, both positive
   function automatic longint vector_angle(longint run, longint rise);
      longint x, y, z, xs, ys;
      x = run <<< 16;
      y = rise <<< 16;
      z = 0;
      for (int i = 0; i < STAGES && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARC_STEPS[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARC_STEPS[i];
         end
      end
      if (z < 0) z = 0;
      if (z > 90 * ONE_DEG) z = 90 * ONE_DEG;
      return z;
   endfunction

   // compass bearing in hundredths of a degree, clockwise from north
   function automatic logic [BRG_W-1:0] compass_bearing(longint dx, longint dy);
      longint ax, ay, ang, turn, scaled;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (dx == 0 && dy == 0) begin
         ang = 0;
      end else if (dy == 0) begin
         ang = ((dx > 0) ? 90 : 270) * ONE_DEG;
      end else if (dx == 0) begin
         ang = ((dy > 0) ? 0 : 180) * ONE_DEG;
      end else begin
         turn = vector_angle(ay, ax);
         if (dy > 0 && dx > 0) ang = turn;
         else if (dy < 0 && dx > 0) ang = 180 * ONE_DEG - turn;
         else if (dy < 0) ang = 180 * ONE_DEG + turn;
         else ang = 360 * ONE_DEG - turn;
      end
      scaled = (ang * 100 + (64'sd1 <<< 23)) >>> 24;
      if (scaled >= 36000) scaled = scaled - 36000;
      return scaled[BRG_W-1:0];
   endfunction

   // square root of ax^2 + ay^2, rounded to nearest
   function automatic logic [DIST_W-1:0] rounded_range(longint ax, longint ay);
      logic [67:0] wx, wy, total, trial, root, rest;
      wx = ax;
      wy = ay;
      total = wx * wx + wy * wy;
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         trial = root | (68'd1 << b);
         if (trial * trial <= total) root = trial;
      end
      rest = total - root * root;
      if (rest > root) root = root + 1;
      return root[DIST_W-1:0];
   endfunction

   // gap length: mostly none, some short, a few long
   function automatic int pick_gap(int none_pct);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < none_pct) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one of the corner values of a coordinate
   function automatic logic signed [IN_W-1:0] pick_corner();
      case ($urandom_range(0, 4))
         0: return PMIN;
         1: return PMAX;
         2: return -32'sd1;
         3: return 32'sd1;
         default: return 32'sd0;
      endcase
   endfunction

   // offer one pair and hold it until the transfer
   task automatic send_pair(input logic signed [IN_W-1:0] rx, ry, tx, ty, input fix_type hint);
      hand_answers.push_back(hint);
      req_bus.ref_x  = rx;
      req_bus.ref_y  = ry;
      req_bus.dest_x = tx;
      req_bus.dest_y = ty;
      req_bus.valid  = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // result side back-pressure
   always @(negedge clock) begin
      if (hold == 0) hold = pick_gap(75);
      if (hold > 0) begin
         rsp_bus.ready = 1'b0;
         hold = hold - 1;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // predict on each pair transfer, check each result transfer, watchdog
   always @(posedge clock) begin
      fix_type want, hint;
      longint  dx, dy, ax, ay, miss_d;
      int      miss_b;
      bit      moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            dx = longint'(req_bus.dest_x) - longint'(req_bus.ref_x);
            dy = longint'(req_bus.dest_y) - longint'(req_bus.ref_y);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            hint = hand_answers.pop_front();
            want = hint;
            if (!hint.known) begin
               want.bearing  = compass_bearing(dx, dy);
               want.distance = rounded_range(ax, ay);
            end
            due_results.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (due_results.size() == 0) begin
               $error("unexpected result: bearing %0d distance %0d",
                      rsp_bus.bearing, rsp_bus.distance);
               fails++;
            end else begin
               want = due_results.pop_front();
               // bearing compared around the circle
               miss_b = int'(rsp_bus.bearing) - int'(want.bearing);
               if (miss_b < 0) miss_b = -miss_b;
               if (miss_b > 18000) miss_b = 36000 - miss_b;
               if (rsp_bus.bearing >= BRG_WRAP || miss_b > BRG_TOL) begin
                  $error("bearing mismatch: expected %0d, actual %0d",
                         want.bearing, rsp_bus.bearing);
                  fails++;
               end
               miss_d = longint'(rsp_bus.distance) - longint'(want.distance);
               if (miss_d < 0) miss_d = -miss_d;
               if (miss_d > DIST_TOL) begin
                  $error("distance mismatch: expected %0d, actual %0d",
                         want.distance, rsp_bus.distance);
                  fails++;
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $error("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      logic signed [IN_W-1:0] rx, ry, tx, ty;
      fix_type                hint;
      int                     g, off_x, off_y, span;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.ref_x  = '0;
      req_bus.ref_y  = '0;
      req_bus.dest_x = '0;
      req_bus.dest_y = '0;
      steady         = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (DIRECTED_CASES[k]) begin
         g = pick_gap(55);
         if (g > 0) begin
            req_bus.valid = 1'b0;
            repeat (g) @(negedge clock);
         end
         hint = '{DIRECTED_CASES[k].known, DIRECTED_CASES[k].bearing,
                  DIRECTED_CASES[k].distance};
         send_pair(DIRECTED_CASES[k].ref_x, DIRECTED_CASES[k].ref_y,
                   DIRECTED_CASES[k].dest_x, DIRECTED_CASES[k].dest_y, hint);
      end

      // random pairs
      hint = '{1'b0, '0, '0};
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = ((n / 60) % 3 == 1);
         // let the pipeline run dry once
         if (n == RANDOM_ITEMS / 2) begin
            req_bus.valid = 1'b0;
            while (due_results.size() != 0) @(posedge clock);
            @(negedge clock);
         end
         g = pick_gap(55);
         if (g > 0) begin
            req_bus.valid = 1'b0;
            repeat (g) @(negedge clock);
         end
         rx = $urandom;
         ry = $urandom;
         tx = $urandom;
         ty = $urandom;
         case ($urandom_range(0, 9))
            // short hops
            4, 5: begin
               off_x = int'($urandom_range(0, 8192)) - 4096;
               off_y = int'($urandom_range(0, 8192)) - 4096;
               tx = rx + off_x;
               ty = ry + off_y;
            end
            // exactly on an axis
            6: begin
               if ($urandom_range(0, 1)) tx = rx;
               else ty = ry;
            end
            // diagonals
            7: begin
               span = $urandom_range(1, 1 << 20);
               tx = $urandom_range(0, 1) ? rx + span : rx - span;
               ty = $urandom_range(0, 1) ? ry + span : ry - span;
            end
            // corner coordinates
            8: begin
               rx = pick_corner();
               ry = pick_corner();
               tx = pick_corner();
               ty = pick_corner();
            end
            // just off an axis
            9: begin
               off_x = $urandom_range(1, 3);
               if ($urandom_range(0, 1)) off_x = -off_x;
               if ($urandom_range(0, 1)) tx = rx + off_x;
               else ty = ry + off_x;
            end
            default: ;
         endcase
         send_pair(rx, ry, tx, ty, hint);
      end
      req_bus.valid = 1'b0;
      steady = 1'b0;

      // drain
      while (due_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fails == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/brgdist_pkg.sv
design/brgdist_if.sv
design/bearing_and_distance_unit.sv
tb/testbench.sv
